### sv/swrs_pkg.sv
// Shared types and constants for the sensor window register sequencer.
package swrs_pkg;

    // Sensor register addresses
    localparam logic [7:0] REG_SOFT_RESET = 8'h0e;
    localparam logic [7:0] REG_MODE       = 8'h40;
    localparam logic [7:0] REG_BIN        = 8'h41;
    localparam logic [7:0] REG_FRAME_H_HI = 8'h50;
    localparam logic [7:0] REG_FRAME_H_LO = 8'h51;
    localparam logic [7:0] REG_FRAME_W_HI = 8'h52;
    localparam logic [7:0] REG_FRAME_W_LO = 8'h53;
    localparam logic [7:0] REG_COL_HI     = 8'h49;
    localparam logic [7:0] REG_COL_LO     = 8'h4a;
    localparam logic [7:0] REG_WIN_W_HI   = 8'h4b;
    localparam logic [7:0] REG_WIN_W_LO   = 8'h4c;
    localparam logic [7:0] REG_ROW_HI     = 8'h45;
    localparam logic [7:0] REG_ROW_LO     = 8'h46;
    localparam logic [7:0] REG_WIN_H_HI   = 8'h47;
    localparam logic [7:0] REG_WIN_H_LO   = 8'h48;
    localparam logic [7:0] REG_CTRL_22    = 8'h22;
    localparam logic [7:0] REG_CTRL_20    = 8'h20;
    localparam logic [7:0] REG_EXP_LO     = 8'h4f;
    localparam logic [7:0] REG_EXP_HI     = 8'h4e;
    localparam logic [7:0] REG_GAIN       = 8'h10;
    localparam logic [7:0] REG_OFFSET     = 8'h23;
    localparam logic [7:0] REG_TRIGGER    = 8'h42;

    // Fixed data bytes
    localparam logic [7:0] SOFT_RESET_ON  = 8'h02;
    localparam logic [7:0] MODE_VALUE     = 8'h6a;
    localparam logic [7:0] BIN_CODE_1     = 8'h10;
    localparam logic [7:0] BIN_CODE_2     = 8'h20;
    localparam logic [7:0] BIN_CODE_4     = 8'h26;
    localparam logic [7:0] EXP_HI_FLAG    = 8'h40;
    localparam logic [7:0] TRIGGER_ON     = 8'h01;
    localparam logic [7:0] BYTE_ZERO      = 8'h00;

    // Size offsets
    localparam logic [15:0] FRAME_H_PAD   = 16'd44;
    localparam logic [15:0] FRAME_W_PAD   = 16'd20;
    localparam logic [15:0] COL_PAD       = 16'd8;
    localparam logic [15:0] ROW_PAD       = 16'd16;

    localparam logic [11:0] TPS_RESET     = 12'd90;

    // Binning factors with a code
    localparam logic [2:0] BIN_X1 = 3'd1;
    localparam logic [2:0] BIN_X2 = 3'd2;
    localparam logic [2:0] BIN_X4 = 3'd4;

    // Write sequence, one state per register write
    typedef enum logic [4:0] {
        ST_SOFT_RST_SET, ST_SOFT_RST_CLR, ST_MODE, ST_BIN,
        ST_FRAME_H_HI, ST_FRAME_H_LO, ST_FRAME_W_HI, ST_FRAME_W_LO,
        ST_COL_HI, ST_COL_LO, ST_WIN_W_HI, ST_WIN_W_LO,
        ST_ROW_HI, ST_ROW_LO, ST_WIN_H_HI, ST_WIN_H_LO,
        ST_CTRL_22, ST_CTRL_20, ST_EXP_LO, ST_EXP_HI, ST_EXP_HI_FLAG,
        ST_GAIN, ST_OFFSET, ST_TRIG_SET, ST_TRIG_CLR
    } seq_state_t;

    // Everything a run needs, derived once at accept
    typedef struct packed {
        logic [15:0] frame_h;
        logic [15:0] frame_w;
        logic [15:0] col_start;
        logic [15:0] win_w;
        logic [15:0] row_start;
        logic [15:0] win_h;
        logic [15:0] ticks;
        logic [7:0]  gain;
        logic [7:0]  offset;
        logic        bin_ok;
        logic [7:0]  bin_code;
    } job_t;

endpackage

### sv/swrs_calc.sv
// Derives the register words of one exposure request from its fields.
module swrs_calc (
    input  logic [11:0]   width_cols,
    input  logic [11:0]   height_rows,
    input  logic [2:0]    bin_factor,
    input  logic [11:0]   start_col,
    input  logic [11:0]   start_row,
    input  logic [15:0]   exposure_time,
    input  logic [7:0]    gain_value,
    input  logic [7:0]    offset_value,
    input  logic [11:0]   ticks_per_second,
    output swrs_pkg::job_t job
);

    logic [15:0] bin16;
    logic [15:0] wb;
    logic [27:0] exp_prod;
    logic [23:0] exp_shift;

    assign bin16     = {13'd0, bin_factor};
    assign wb        = {4'd0, width_cols} * bin16;
    assign exp_prod  = {12'd0, exposure_time} * {16'd0, ticks_per_second};
    assign exp_shift = exp_prod[27:4];

    always_comb
    begin
        job.frame_h   = {4'd0, height_rows} + swrs_pkg::FRAME_H_PAD;
        job.frame_w   = wb + swrs_pkg::FRAME_W_PAD;
        job.col_start = {4'd0, start_col} * bin16 + swrs_pkg::COL_PAD;
        job.win_w     = wb;
        job.row_start = {4'd0, start_row} * bin16 + swrs_pkg::ROW_PAD;
        job.win_h     = {4'd0, height_rows} * bin16;
        // zero check is on the whole shifted product, not its low 16 bits
        job.ticks     = (exp_shift == 24'd0) ? 16'd1 : exp_shift[15:0];
        job.gain      = gain_value;
        job.offset    = offset_value;
        case (bin_factor)
            swrs_pkg::BIN_X1:
            begin
                job.bin_ok   = 1'b1;
                job.bin_code = swrs_pkg::BIN_CODE_1;
            end
            swrs_pkg::BIN_X2:
            begin
                job.bin_ok   = 1'b1;
                job.bin_code = swrs_pkg::BIN_CODE_2;
            end
            swrs_pkg::BIN_X4:
            begin
                job.bin_ok   = 1'b1;
                job.bin_code = swrs_pkg::BIN_CODE_4;
            end
            default:
            begin
                job.bin_ok   = 1'b0;
                job.bin_code = swrs_pkg::BYTE_ZERO;
            end
        endcase
    end

endmodule

### sv/sensor_window_register_sequencer_top.sv
// Top level: exposure request in, ordered sensor register writes out.
//
// Input channel (in_valid/in_stall) carries one start-exposure request per
// transaction. Output channel (out_valid/out_stall) carries one register
// write per transaction: reg_addr, reg_data, and last_write on the final
// write of the run. All writes target device 0x66, which is implied.
// The ticks_per_second register is written with cfg_write_en/cfg_write_data;
// the user must write it only while the block is idle, which the block
// itself does not enforce. A request is registered into the job register
// at accept, and each write then passes through the output register. A run
// is 25 writes, or 24 when the bin factor has no code. Writes leave at one
// per cycle while out_stall is low; the single output register sets that
// rate. The next request is accepted in the cycle the last write of a run is
// loaded into the output register, so runs follow each other without a gap.
// Reset clears the run and output valid, and sets ticks_per_second to 90.
// While out_stall is high the current write holds and the sequence pauses;
// in_stall stays high until the run's last write has been loaded.
module sensor_window_register_sequencer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [11:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] width_cols,
    input  logic [11:0] height_rows,
    input  logic [2:0]  bin_factor,
    input  logic [11:0] start_col,
    input  logic [11:0] start_row,
    input  logic [15:0] exposure_time,
    input  logic [7:0]  gain_value,
    input  logic [7:0]  offset_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  reg_addr,
    output logic [7:0]  reg_data,
    output logic        last_write
);

    logic [11:0]             tps_reg;
    swrs_pkg::job_t          job_calc;
    swrs_pkg::job_t          job_reg;
    logic                    job_valid_reg;
    logic                    job_valid_next;
    swrs_pkg::seq_state_t    state_reg;
    swrs_pkg::seq_state_t    state_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [7:0]              addr_reg;
    logic [7:0]              data_reg;
    logic                    last_reg;
    logic [7:0]              wr_addr;
    logic [7:0]              wr_data;
    logic                    wr_last;
    logic                    emit;
    logic                    in_accept;

    swrs_calc u_calc (
        .width_cols       (width_cols),
        .height_rows      (height_rows),
        .bin_factor       (bin_factor),
        .start_col        (start_col),
        .start_row        (start_row),
        .exposure_time    (exposure_time),
        .gain_value       (gain_value),
        .offset_value     (offset_value),
        .ticks_per_second (tps_reg),
        .job              (job_calc)
    );

    // a write moves into the output register when it is empty or draining
    assign emit      = job_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = job_valid_reg && !(emit && wr_last);
    assign in_accept = in_valid && !in_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (in_accept)
        begin
            state_next = swrs_pkg::ST_SOFT_RST_SET;
        end
        else if (emit)
        begin
            if (state_reg == swrs_pkg::ST_MODE && !job_reg.bin_ok)
            begin
                state_next = swrs_pkg::ST_FRAME_H_HI;
            end
            else if (state_reg == swrs_pkg::ST_TRIG_CLR)
            begin
                state_next = swrs_pkg::ST_SOFT_RST_SET;
            end
            else
            begin
                state_next = swrs_pkg::seq_state_t'(state_reg + 5'd1);
            end
        end
    end

    // write produced by the current state
    always_comb
    begin
        wr_last = 1'b0;
        case (state_reg)
            swrs_pkg::ST_SOFT_RST_SET:
            begin
                wr_addr = swrs_pkg::REG_SOFT_RESET;
                wr_data = swrs_pkg::SOFT_RESET_ON;
            end
            swrs_pkg::ST_SOFT_RST_CLR:
            begin
                wr_addr = swrs_pkg::REG_SOFT_RESET;
                wr_data = swrs_pkg::BYTE_ZERO;
            end
            swrs_pkg::ST_MODE:
            begin
                wr_addr = swrs_pkg::REG_MODE;
                wr_data = swrs_pkg::MODE_VALUE;
            end
            swrs_pkg::ST_BIN:
            begin
                wr_addr = swrs_pkg::REG_BIN;
                wr_data = job_reg.bin_code;
            end
            swrs_pkg::ST_FRAME_H_HI:
            begin
                wr_addr = swrs_pkg::REG_FRAME_H_HI;
                wr_data = job_reg.frame_h[15:8];
            end
            swrs_pkg::ST_FRAME_H_LO:
            begin
                wr_addr = swrs_pkg::REG_FRAME_H_LO;
                wr_data = job_reg.frame_h[7:0];
            end
            swrs_pkg::ST_FRAME_W_HI:
            begin
                wr_addr = swrs_pkg::REG_FRAME_W_HI;
                wr_data = job_reg.frame_w[15:8];
            end
            swrs_pkg::ST_FRAME_W_LO:
            begin
                wr_addr = swrs_pkg::REG_FRAME_W_LO;
                wr_data = job_reg.frame_w[7:0];
            end
            swrs_pkg::ST_COL_HI:
            begin
                wr_addr = swrs_pkg::REG_COL_HI;
                wr_data = job_reg.col_start[15:8];
            end
            swrs_pkg::ST_COL_LO:
            begin
                wr_addr = swrs_pkg::REG_COL_LO;
                wr_data = job_reg.col_start[7:0];
            end
            swrs_pkg::ST_WIN_W_HI:
            begin
                wr_addr = swrs_pkg::REG_WIN_W_HI;
                wr_data = job_reg.win_w[15:8];
            end
            swrs_pkg::ST_WIN_W_LO:
            begin
                wr_addr = swrs_pkg::REG_WIN_W_LO;
                wr_data = job_reg.win_w[7:0];
            end
            swrs_pkg::ST_ROW_HI:
            begin
                wr_addr = swrs_pkg::REG_ROW_HI;
                wr_data = job_reg.row_start[15:8];
            end
            swrs_pkg::ST_ROW_LO:
            begin
                wr_addr = swrs_pkg::REG_ROW_LO;
                wr_data = job_reg.row_start[7:0];
            end
            swrs_pkg::ST_WIN_H_HI:
            begin
                wr_addr = swrs_pkg::REG_WIN_H_HI;
                wr_data = job_reg.win_h[15:8];
            end
            swrs_pkg::ST_WIN_H_LO:
            begin
                wr_addr = swrs_pkg::REG_WIN_H_LO;
                wr_data = job_reg.win_h[7:0];
            end
            swrs_pkg::ST_CTRL_22:
            begin
                wr_addr = swrs_pkg::REG_CTRL_22;
                wr_data = swrs_pkg::BYTE_ZERO;
            end
            swrs_pkg::ST_CTRL_20:
            begin
                wr_addr = swrs_pkg::REG_CTRL_20;
                wr_data = swrs_pkg::BYTE_ZERO;
            end
            swrs_pkg::ST_EXP_LO:
            begin
                wr_addr = swrs_pkg::REG_EXP_LO;
                wr_data = job_reg.ticks[7:0];
            end
            swrs_pkg::ST_EXP_HI:
            begin
                wr_addr = swrs_pkg::REG_EXP_HI;
                wr_data = job_reg.ticks[15:8];
            end
            swrs_pkg::ST_EXP_HI_FLAG:
            begin
                // high byte again with the latch flag, wraps mod 256
                wr_addr = swrs_pkg::REG_EXP_HI;
                wr_data = job_reg.ticks[15:8] + swrs_pkg::EXP_HI_FLAG;
            end
            swrs_pkg::ST_GAIN:
            begin
                wr_addr = swrs_pkg::REG_GAIN;
                wr_data = job_reg.gain;
            end
            swrs_pkg::ST_OFFSET:
            begin
                wr_addr = swrs_pkg::REG_OFFSET;
                wr_data = job_reg.offset;
            end
            swrs_pkg::ST_TRIG_SET:
            begin
                wr_addr = swrs_pkg::REG_TRIGGER;
                wr_data = swrs_pkg::TRIGGER_ON;
            end
            swrs_pkg::ST_TRIG_CLR:
            begin
                wr_addr = swrs_pkg::REG_TRIGGER;
                wr_data = swrs_pkg::BYTE_ZERO;
                wr_last = 1'b1;
            end
            default:
            begin
                wr_addr = swrs_pkg::BYTE_ZERO;
                wr_data = swrs_pkg::BYTE_ZERO;
            end
        endcase
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (in_accept)
        begin
            job_valid_next = 1'b1;
        end
        else if (emit && wr_last)
        begin
            job_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg       <= swrs_pkg::TPS_RESET;
            job_valid_reg <= 1'b0;
            state_reg     <= swrs_pkg::ST_SOFT_RST_SET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                tps_reg <= cfg_write_data;
            end
            job_valid_reg <= job_valid_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            job_reg <= job_calc;
        end
        if (emit)
        begin
            addr_reg <= wr_addr;
            data_reg <= wr_data;
            last_reg <= wr_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign reg_addr   = addr_reg;
    assign reg_data   = data_reg;
    assign last_write = last_reg;

endmodule
